// ===== rtl/ed_pkg.sv =====
// ----------------------------------------------------------------------------
// ed_pkg
// Shared widths, constants and the accumulator-to-root queue entry type for
// the Euclidean distance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ed_pkg;

   localparam int SAMPLE_W = 16;
   localparam int DIFF_W   = SAMPLE_W + 1;     // a - b
   localparam int MAG_W    = SAMPLE_W + 1;     // |a - b| below 2^16
   localparam int SQ_W     = 2 * SAMPLE_W + 1; // square below 2^32
   localparam int SUM_W    = 48;
   localparam int DIST_W   = SUM_W / 2;

   // first trial bit of the root search: highest even power of two in SUM_W
   localparam logic [SUM_W-1:0] ROOT_BIT_INIT = {2'b01, {(SUM_W-2){1'b0}}};

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             sat;
   } sum_entry_type;

endpackage

// ===== rtl/ed_front.sv =====
// ----------------------------------------------------------------------------
// ed_front
// Takes sample pairs, squares the difference and keeps the running sum with
// saturation. A pair flagged last pushes the final sum into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ed_front
   import ed_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_a,
   input  logic signed [SAMPLE_W-1:0] req_sample_b,
   input  logic                       req_last,
   output logic                       push,
   output sum_entry_type              push_data,
   input  logic                       queue_full
);

   logic                    s1_valid_ff, s1_valid_in;
   logic [MAG_W-1:0]        s1_mag_ff;
   logic                    s1_last_ff;
   logic                    s2_valid_ff, s2_valid_in;
   logic [SQ_W-1:0]         s2_sq_ff;
   logic                    s2_last_ff;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic                    sat_ff, sat_in;

   logic                    advance;
   logic signed [DIFF_W-1:0] diff;
   logic [MAG_W-1:0]        mag;
   logic [2*MAG_W-1:0]      product;
   logic [SUM_W:0]          total;
   logic [SUM_W-1:0]        sum_next;
   logic                    sat_next;

   // the whole front stalls only when a final sum has nowhere to go
   assign advance   = !(s2_valid_ff && s2_last_ff && queue_full);
   assign req_ready = advance;

   assign diff    = DIFF_W'(req_sample_a) - DIFF_W'(req_sample_b);
   assign mag     = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
   assign product = s1_mag_ff * s1_mag_ff;

   assign total    = {1'b0, sum_ff} + (SUM_W+1)'(s2_sq_ff);
   assign sum_next = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
   assign sat_next = sat_ff | total[SUM_W];

   assign push           = s2_valid_ff && s2_last_ff && advance;
   assign push_data.sum  = sum_next;
   assign push_data.sat  = sat_next;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      sum_in      = sum_ff;
      sat_in      = sat_ff;
      if (advance) begin
         s1_valid_in = req_valid;
         s2_valid_in = s1_valid_ff;
         if (s2_valid_ff) begin
            if (s2_last_ff) begin
               sum_in = '0;
               sat_in = 1'b0;
            end else begin
               sum_in = sum_next;
               sat_in = sat_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sum_ff      <= '0;
         sat_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         sum_ff      <= sum_in;
         sat_ff      <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mag_ff  <= mag;
         s1_last_ff <= req_last;
         s2_sq_ff   <= product[SQ_W-1:0];
         s2_last_ff <= s1_last_ff;
      end
   end

endmodule

// ===== rtl/ed_queue.sv =====
// ----------------------------------------------------------------------------
// ed_queue
// Short queue of final sums between the accumulator and the root unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ed_queue
   import ed_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  sum_entry_type push_data,
   output logic          full,
   input  logic          pop,
   output sum_entry_type pop_data,
   output logic          empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sum_entry_type     entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/ed_root.sv =====
// ----------------------------------------------------------------------------
// ed_root
// Bit-serial floor square root of a queued sum, one result bit per cycle,
// with a result register on the output channel that the last bit waits for.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ed_root
   import ed_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   output logic              pop,
   input  sum_entry_type     pop_data,
   input  logic              queue_empty,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DIST_W-1:0] rsp_distance,
   output logic              rsp_overflow
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   logic              state_ff, state_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  root_ff, root_in;
   logic [SUM_W-1:0]  bit_ff, bit_in;
   logic              sat_ff, sat_in;
   logic              out_valid_ff, out_valid_in;
   logic [DIST_W-1:0] out_dist_ff;
   logic              out_ovf_ff;

   logic [SUM_W-1:0]  trial;
   logic              fits;
   logic [SUM_W-1:0]  root_step;
   logic              out_free;
   logic              step;
   logic              finish;

   assign trial     = root_ff + bit_ff;
   assign fits      = (rem_ff >= trial);
   assign root_step = fits ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);
   assign out_free  = !out_valid_ff || rsp_ready;

   // last trial bit holds until the result register can take the root
   assign step   = (state_ff == ST_BUSY) && (!bit_ff[0] || out_free);
   assign finish = step && bit_ff[0];
   assign pop    = (state_ff == ST_IDLE) && !queue_empty;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      sat_in       = sat_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               rem_in   = pop_data.sum;
               root_in  = '0;
               bit_in   = ROOT_BIT_INIT;
               sat_in   = pop_data.sat;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (step) begin
               if (fits) begin
                  rem_in = rem_ff - trial;
               end
               root_in = root_step;
               bit_in  = bit_ff >> 2;
            end
            if (finish) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      sat_ff  <= sat_in;
      if (finish) begin
         out_dist_ff <= root_step[DIST_W-1:0];
         out_ovf_ff  <= sat_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_distance = out_dist_ff;
   assign rsp_overflow = out_ovf_ff;

endmodule

// ===== rtl/euclidean_distance.sv =====
// ----------------------------------------------------------------------------
// euclidean_distance
// Streams pairs of signed Q8.8 samples and sums the squared differences in a
// 48-bit Q32.16 accumulator that saturates and flags overflow. The pair marked
// last closes the series: its final sum goes through a short queue to a
// bit-serial square root, which returns the floor root as a Q16.8 distance.
// Sample pairs are taken one per clock; the accumulator front only stalls
// when a final sum meets a full queue. The root unit pops a new sum only
// when idle and works out its result bits one at a time, so series shorter
// than a root computation fill the queue. A pair passes the s1 magnitude
// and s2 square registers before it reaches the accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euclidean_distance
   import ed_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_a,
   input  logic signed [SAMPLE_W-1:0] req_sample_b,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DIST_W-1:0]          rsp_distance,
   output logic                       rsp_overflow
);

   logic          push;
   sum_entry_type push_data;
   logic          queue_full;
   logic          pop;
   sum_entry_type pop_data;
   logic          queue_empty;

   ed_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample_a (req_sample_a),
      .req_sample_b (req_sample_b),
      .req_last     (req_last),
      .push         (push),
      .push_data    (push_data),
      .queue_full   (queue_full)
   );

   ed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   ed_root u_root (
      .clock        (clock),
      .reset        (reset),
      .pop          (pop),
      .pop_data     (pop_data),
      .queue_empty  (queue_empty),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_distance (rsp_distance),
      .rsp_overflow (rsp_overflow)
   );

endmodule
